[src/price_level_order_book_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the price level order book
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PLOB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("order book assertion failed");
// next-cycle implication
`define PLOB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("order book assertion failed");
`else
`define PLOB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PLOB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[src/plob_pkg.sv]
// ----------------------------------------------------------------------------
// plob_pkg
// Types and constants shared by the order book modules.
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int LVL       = 64;
    localparam int IDX_W     = (LVL > 2) ? $clog2(LVL) : 1;
    localparam int CNT_W     = $clog2(LVL + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

    localparam logic signed [47:0] ONE_UNIT = 48'sd100000000;

    typedef enum logic [1:0] {
        OP_UPDATE    = 2'd0,
        OP_QUERY_BID = 2'd1,
        OP_QUERY_ASK = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_HIT,
        S_MISS,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_QRY_RD,
        S_QRY_EMIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [47:0]        price;
        logic signed [47:0] amount;
        logic [15:0]        count;
    } level_t;

    typedef struct packed {
        logic [47:0]        level_price;
        logic signed [47:0] level_amount;
        logic [15:0]        level_count;
        logic               level_valid;
        logic signed [55:0] side_total_amount;
        logic [22:0]        side_total_count;
        logic               last;
        status_t            status;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        level_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

[src/price_level_order_book.sv]
// ----------------------------------------------------------------------------
// price_level_order_book
// Level-2 order book: sorted bid and ask level tables with running totals.
// ----------------------------------------------------------------------------
// Works on one word at a time. Both sides share one 112-bit RAM (bids in the
// low half, asks in the high half); a level lookup scans the side linearly,
// reading each entry and then comparing it, so an update first walks to its
// level, then moves entries one by one, read then write, when an insert opens
// a slot or a delete closes one, and ends in the result state. A query reads
// each returned level from RAM and then emits it, and may stall on the output;
// clear or an ignored update goes straight to the result. The one RAM read
// port sets this pace. The result register lets the engine start the next word
// while the last result still waits. No clearing pass is needed after reset:
// only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`include "price_level_order_book_assert.svh"

module price_level_order_book (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [47:0]        s_price,
    input  logic [15:0]        s_order_count,
    input  logic signed [47:0] s_amount,
    input  logic [6:0]         s_query_depth,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [47:0]        m_level_price,
    output logic signed [47:0] m_level_amount,
    output logic [15:0]        m_level_count,
    output logic               m_level_valid,
    output logic signed [55:0] m_side_total_amount,
    output logic [22:0]        m_side_total_count,
    output logic               m_last,
    output logic [1:0]         m_status
);
    import plob_pkg::*;

    ram_req_t         ram_req;
    logic [$bits(level_t)-1:0] ram_rdata_raw;
    level_t           ram_rdata;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             m_valid_reg, m_valid_next;
    res_t             out_reg, out_next;

    plob_ram #(
        .WIDTH ($bits(level_t)),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = level_t'(ram_rdata_raw);

    plob_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_price       (s_price),
        .s_order_count (s_order_count),
        .s_amount      (s_amount),
        .s_query_depth (s_query_depth),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // output word register: refill when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_level_price       = out_reg.level_price;
    assign m_level_amount      = out_reg.level_amount;
    assign m_level_count       = out_reg.level_count;
    assign m_level_valid       = out_reg.level_valid;
    assign m_side_total_amount = out_reg.side_total_amount;
    assign m_side_total_count  = out_reg.side_total_count;
    assign m_last              = out_reg.last;
    assign m_status            = out_reg.status;

    `PLOB_ASSERT_NXT(a_res_loads_out, aclk, aresetn, res_valid && res_ready, m_valid)
    `PLOB_ASSERT_IMP(a_no_load_when_full, aclk, aresetn, m_valid && !m_ready, !res_ready)
    `PLOB_ASSERT_IMP(a_rd_wr_apart, aclk, aresetn, ram_req.we && ram_req.re,
                     ram_req.waddr != ram_req.raddr)

endmodule

[src/plob_ram.sv]
// ----------------------------------------------------------------------------
// plob_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/plob_engine.sv]
// ----------------------------------------------------------------------------
// plob_engine
// Sequencer: scans, shifts and rewrites the level table, keeps totals.
// ----------------------------------------------------------------------------
`include "price_level_order_book_assert.svh"

module plob_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_operation,
    input  logic [47:0]               s_price,
    input  logic [15:0]               s_order_count,
    input  logic signed [47:0]        s_amount,
    input  logic [6:0]                s_query_depth,
    output plob_pkg::ram_req_t        ram_req,
    input  plob_pkg::level_t          ram_rdata,
    output logic                      res_valid,
    input  logic                      res_ready,
    output plob_pkg::res_t            res
);
    import plob_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    used_reg [2];
    logic [CNT_W-1:0]    used_next [2];
    logic signed [55:0]  tamt_reg [2];
    logic signed [55:0]  tamt_next [2];
    logic [22:0]         tcnt_reg [2];
    logic [22:0]         tcnt_next [2];
    logic                side_reg, side_next;     // 0 bid, 1 ask
    logic                del_reg, del_next;
    logic                zero_reg, zero_next;     // result totals forced to zero
    status_t             st_reg, st_next;
    level_t              lvl_reg, lvl_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    n_reg, n_next;

    logic                dec_side;
    logic                dec_del;
    logic                dec_ok;
    logic [CNT_W-1:0]    used_s;
    logic [CNT_W-1:0]    q_used;
    logic [CNT_W-1:0]    q_n;
    logic                q_side;
    logic signed [55:0]  new_amt_ext;
    logic signed [55:0]  old_amt_ext;
    logic [22:0]         new_cnt_ext;
    logic [22:0]         old_cnt_ext;
    logic                before_hit;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    idx_dec;

    assign used_s      = used_reg[side_reg];
    assign new_amt_ext = 56'(lvl_reg.amount);
    assign old_amt_ext = 56'(ram_rdata.amount);
    assign new_cnt_ext = 23'(lvl_reg.count);
    assign old_cnt_ext = 23'(ram_rdata.count);
    assign idx_inc     = idx_reg + 1'b1;
    assign idx_dec     = idx_reg - 1'b1;
    // bids run descending, asks ascending
    assign before_hit  = side_reg ? (ram_rdata.price > lvl_reg.price)
                                  : (ram_rdata.price < lvl_reg.price);

    always_comb begin
        dec_ok   = 1'b1;
        dec_side = 1'b0;
        dec_del  = 1'b0;
        if (s_order_count != 16'd0 && s_amount > 48'sd0) begin
            dec_side = 1'b0;
        end else if (s_order_count != 16'd0 && s_amount < 48'sd0) begin
            dec_side = 1'b1;
        end else if (s_order_count == 16'd0 && s_amount == ONE_UNIT) begin
            dec_del  = 1'b1;
        end else if (s_order_count == 16'd0 && s_amount == -ONE_UNIT) begin
            dec_side = 1'b1;
            dec_del  = 1'b1;
        end else begin
            dec_ok   = 1'b0;
        end
        q_side = (op_t'(s_operation) == OP_QUERY_ASK);
        q_used = used_reg[q_side];
        q_n    = (7'(s_query_depth) < 7'(q_used)) ? s_query_depth[CNT_W-1:0] : q_used;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg[0] <= '0;
            used_reg[1] <= '0;
            tamt_reg[0] <= '0;
            tamt_reg[1] <= '0;
            tcnt_reg[0] <= '0;
            tcnt_reg[1] <= '0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            tamt_reg    <= tamt_next;
            tcnt_reg    <= tcnt_next;
        end
        side_reg <= side_next;
        del_reg  <= del_next;
        zero_reg <= zero_next;
        st_reg   <= st_next;
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        n_reg    <= n_next;
    end

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        tamt_next  = tamt_reg;
        tcnt_next  = tcnt_reg;
        side_next  = side_reg;
        del_next   = del_reg;
        zero_next  = zero_reg;
        st_next    = st_reg;
        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        s_ready    = 1'b0;
        ram_req    = '0;
        res_valid  = 1'b0;
        res        = '0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    lvl_next.price  = s_price;
                    lvl_next.amount = s_amount;
                    lvl_next.count  = s_order_count;
                    idx_next        = '0;
                    zero_next       = 1'b0;
                    st_next         = ST_OK;
                    case (op_t'(s_operation))
                        OP_UPDATE: begin
                            side_next = dec_side;
                            del_next  = dec_del;
                            if (dec_ok) begin
                                state_next = S_SCAN_RD;
                            end else begin
                                zero_next  = 1'b1;
                                st_next    = ST_IGNORED;
                                state_next = S_RESULT;
                            end
                        end
                        OP_QUERY_BID, OP_QUERY_ASK: begin
                            side_next  = q_side;
                            n_next     = q_n;
                            state_next = (q_n == '0) ? S_RESULT : S_QRY_RD;
                        end
                        default: begin
                            used_next[0] = '0;
                            used_next[1] = '0;
                            tamt_next[0] = '0;
                            tamt_next[1] = '0;
                            tcnt_next[0] = '0;
                            tcnt_next[1] = '0;
                            zero_next    = 1'b1;
                            state_next   = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == used_s) begin
                    pos_next   = idx_reg;
                    state_next = S_MISS;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = {side_reg, idx_reg[IDX_W-1:0]};
                    state_next    = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                pos_next = idx_reg;
                if (ram_rdata.price == lvl_reg.price) begin
                    state_next = S_HIT;
                end else if (before_hit) begin
                    state_next = S_MISS;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_HIT: begin
                if (!del_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = {side_reg, pos_reg[IDX_W-1:0]};
                    ram_req.wdata = lvl_reg;
                    tamt_next[side_reg] = tamt_reg[side_reg] - old_amt_ext + new_amt_ext;
                    tcnt_next[side_reg] = tcnt_reg[side_reg] - old_cnt_ext + new_cnt_ext;
                    state_next = S_RESULT;
                end else begin
                    tamt_next[side_reg] = tamt_reg[side_reg] - old_amt_ext;
                    tcnt_next[side_reg] = tcnt_reg[side_reg] - old_cnt_ext;
                    idx_next   = pos_reg;
                    state_next = S_DN_RD;
                end
            end
            S_MISS: begin
                if (del_reg) begin
                    st_next    = ST_MISSING;
                    state_next = S_RESULT;
                end else if (32'(used_s) >= LVL) begin
                    st_next    = ST_FULL;
                    state_next = S_RESULT;
                end else begin
                    idx_next   = used_s;
                    state_next = S_UP_RD;
                end
            end
            // open a slot at pos by moving entries up, top first
            S_UP_RD: begin
                if (idx_reg == pos_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = {side_reg, idx_dec[IDX_W-1:0]};
                    state_next    = S_UP_WR;
                end
            end
            S_UP_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {side_reg, idx_reg[IDX_W-1:0]};
                ram_req.wdata = ram_rdata;
                idx_next      = idx_dec;
                state_next    = S_UP_RD;
            end
            S_INS_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {side_reg, pos_reg[IDX_W-1:0]};
                ram_req.wdata = lvl_reg;
                used_next[side_reg] = used_s + 1'b1;
                tamt_next[side_reg] = tamt_reg[side_reg] + new_amt_ext;
                tcnt_next[side_reg] = tcnt_reg[side_reg] + new_cnt_ext;
                state_next = S_RESULT;
            end
            // close the gap at pos by moving entries down
            S_DN_RD: begin
                if (idx_inc >= used_s) begin
                    used_next[side_reg] = used_s - 1'b1;
                    state_next = S_RESULT;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = {side_reg, idx_inc[IDX_W-1:0]};
                    state_next    = S_DN_WR;
                end
            end
            S_DN_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {side_reg, idx_reg[IDX_W-1:0]};
                ram_req.wdata = ram_rdata;
                idx_next      = idx_inc;
                state_next    = S_DN_RD;
            end
            S_QRY_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = {side_reg, idx_reg[IDX_W-1:0]};
                state_next    = S_QRY_EMIT;
            end
            S_QRY_EMIT: begin
                res_valid             = 1'b1;
                res.level_price       = ram_rdata.price;
                res.level_amount      = ram_rdata.amount;
                res.level_count       = ram_rdata.count;
                res.level_valid       = 1'b1;
                res.side_total_amount = tamt_reg[side_reg];
                res.side_total_count  = tcnt_reg[side_reg];
                res.last              = (idx_inc == n_reg);
                res.status            = ST_OK;
                if (res_ready) begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == n_reg) ? S_IDLE : S_QRY_RD;
                end
            end
            S_RESULT: begin
                res_valid             = 1'b1;
                res.side_total_amount = zero_reg ? 56'sd0 : tamt_reg[side_reg];
                res.side_total_count  = zero_reg ? 23'd0 : tcnt_reg[side_reg];
                res.last              = 1'b1;
                res.status            = st_reg;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PLOB_ASSERT_IMP(a_bid_used_cap, aclk, aresetn, 1'b1, 32'(used_reg[0]) <= LVL)
    `PLOB_ASSERT_IMP(a_ask_used_cap, aclk, aresetn, 1'b1, 32'(used_reg[1]) <= LVL)
    `PLOB_ASSERT_IMP(a_shift_up_range, aclk, aresetn, state_reg == S_UP_WR, idx_reg > pos_reg)
    `PLOB_ASSERT_IMP(a_query_range, aclk, aresetn, state_reg == S_QRY_EMIT, idx_reg < n_reg)

endmodule
